>>> rtl/stld_pkg.sv
// Shared types and constants for the sync/type/length deframer.
// Used by stld_parser, sync_type_length_deframer_unit and the port checker.
// No dependencies.
package stld_pkg;

    // Largest payload accepted; longer frames are dropped
    localparam int MAX_PAYLOAD = 128;

    // Field widths of a result beat
    localparam int BYTE_W  = 8;
    localparam int FLEN_W  = 8;
    localparam int FIDX_W  = 7;

    // Held length and payload counter widths follow MAX_PAYLOAD
    localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int CNT_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CMP_W   = LEN_W + 1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_FIRST  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_SECOND = 1'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h5a;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h50;

    // Packed result tdata: type, length, data, index, padded to bytes
    localparam int M_TDATA_W = 32;

    // Parse phase
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_DATA   = 3'd5
    } stld_phase_t;

    // One result beat
    typedef struct packed {
        logic              is_empty;
        logic              is_last;
        logic [FIDX_W-1:0] byte_index;
        logic [BYTE_W-1:0] data_byte;
        logic [FLEN_W-1:0] frame_length;
        logic [BYTE_W-1:0] frame_type;
    } stld_result_t;

endpackage

>>> rtl/stld_parser.sv
// Frame parser: phase machine, held type/length and payload counter.
// Produces at most one result per accepted byte, combinationally.
// Depends on stld_pkg.
module stld_parser
    import stld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               byte_accept,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic [BYTE_W-1:0]  sync_first,
    input  logic [BYTE_W-1:0]  sync_second,
    output logic               res_valid,
    output stld_result_t       res
);

    stld_phase_t        phase_reg, phase_next;
    logic [BYTE_W-1:0]  type_reg, type_next;
    logic [BYTE_W-1:0]  len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [15:0]        len_full;
    logic               len_too_big;
    logic               len_zero;
    logic               last_byte;

    // Full length once the high byte arrives
    assign len_full    = {in_byte, len_lo_reg};
    assign len_too_big = len_full > 16'(MAX_PAYLOAD);
    assign len_zero    = len_full == 16'd0;
    assign last_byte   = (CMP_W'(cnt_reg) + CMP_W'(1)) >= CMP_W'(len_reg);

    // Next phase and held values
    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_lo_next = len_lo_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        if (byte_accept) begin
            unique case (phase_reg)
                PH_SYNC2: begin
                    if (in_byte == sync_second) begin
                        phase_next = PH_TYPE;
                    end else if (in_byte == sync_first) begin
                        phase_next = PH_SYNC2;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_TYPE: begin
                    type_next  = in_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_lo_next = in_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_next = LEN_W'(len_full);
                    cnt_next = '0;
                    if (len_too_big || len_zero) begin
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (last_byte) begin
                        phase_next = PH_HUNT;
                    end
                end
                default: begin
                    phase_next = (in_byte == sync_first) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    // Result for the byte on the input
    always_comb begin
        res_valid        = 1'b0;
        res.frame_type   = type_reg;
        res.frame_length = FLEN_W'(len_reg);
        res.data_byte    = '0;
        res.byte_index   = '0;
        res.is_last      = 1'b0;
        res.is_empty     = 1'b0;
        unique case (phase_reg)
            PH_LEN_HI: begin
                // zero length gives one empty-frame beat
                res_valid        = !len_too_big && len_zero;
                res.frame_length = '0;
                res.is_last      = 1'b1;
                res.is_empty     = 1'b1;
            end
            PH_DATA: begin
                res_valid      = 1'b1;
                res.data_byte  = in_byte;
                res.byte_index = FIDX_W'(cnt_reg);
                res.is_last    = last_byte;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            type_reg   <= '0;
            len_lo_reg <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_lo_reg <= len_lo_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/sync_type_length_deframer_unit.sv
// Top level of the sync/type/length deframer: config registers, parser
// and registered result stage. Depends on stld_pkg and stld_parser.
//
// Output: a result beat appears on m_ in the cycle after its byte is taken.
// Throughput: one byte per cycle; s_tready drops only while a result beat
// waits on m_ and m_tready is low.
// Reset (aresetn low, synchronous): hunting for the first sync byte, sync
// registers back to 0x5a / 0x50, result stage empty.
module sync_type_length_deframer_unit
    import stld_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]     cfg_wdata,
    // input byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] frame_type, [15:8] frame_length,
                                             // [23:16] data_byte, [30:24] byte_index,
                                             // [31] zero
    output logic                  m_tlast,   // is_last
    output logic                  m_tuser    // is_empty
);

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;

    logic              s_accept;
    logic              res_valid;
    stld_result_t      res;

    logic              out_valid_reg, out_valid_next;
    stld_result_t      out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Take a byte whenever the result stage is free or being emptied
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    stld_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .in_byte     (s_tdata),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result stage
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.byte_index, out_reg.data_byte,
                       out_reg.frame_length, out_reg.frame_type};
    assign m_tlast  = out_reg.is_last;
    assign m_tuser  = out_reg.is_empty;

endmodule

>>> rtl/stld_port_checker.sv
// Port-level checks for sync_type_length_deframer_unit, bound to the top.
// Depends on stld_pkg.
module stld_port_checker
    import stld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 m_tuser
);

    // A held result beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Input is only stalled by a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // Empty frame beat: last, zero length, zero data and index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[31:8] == 24'd0))
        else $error("malformed empty-frame beat");

    // Payload beats stay within the announced length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[15:8] <= 8'(MAX_PAYLOAD))
            && ({1'b0, m_tdata[30:24]} < m_tdata[15:8]) && !m_tdata[31])
        else $error("payload index outside frame length");

    // The final payload beat sits at index length - 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tlast |-> ({1'b0, m_tdata[30:24]} + 8'd1 == m_tdata[15:8]))
        else $error("last beat at wrong index");

endmodule

bind sync_type_length_deframer_unit stld_port_checker u_stld_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> tb/tb_top.sv
// Self-checking testbench for sync_type_length_deframer_unit: byte driver, result
// monitor and an in-bench frame parser that predicts every result beat.
// Depends on stld_pkg and the deframer RTL.
module tb_top;
    import stld_pkg::*;

    localparam int CYCLE_LIMIT = 150000;
    localparam int BYTES_PER_PHASE = 230;
    localparam int N_PHASES = 5;

    // One byte waiting to go out; drain holds it until all results are back
    typedef struct {
        logic [BYTE_W-1:0] value;
        bit                drain;
    } link_byte_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = CFG_SYNC_FIRST;
    logic [BYTE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // [7:0] type, [15:8] length, [23:16] data,
                                      // [30:24] index, [31] zero
    logic                  m_tlast;   // is_last
    logic                  m_tuser;   // is_empty

    sync_type_length_deframer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Parser copy: sync bytes and frame state
    logic [BYTE_W-1:0] sync_first_cfg  = SYNC_FIRST_RST;
    logic [BYTE_W-1:0] sync_second_cfg = SYNC_SECOND_RST;
    stld_phase_t       deframe_phase   = PH_HUNT;
    logic [7:0]        held_type       = '0;
    logic [15:0]       held_len        = '0;
    logic [10:0]       payload_count   = '0;

    link_byte_t   bytes_to_send[$];
    stld_result_t frame_beats_due[$];
    link_byte_t   next_byte;
    stld_result_t got_beat;
    stld_result_t want_beat;
    int           send_gap = 0;
    int           stall_left = 0;
    int           stall_draw;
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;
    bit           hold_for_drain = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Advance the parser by one accepted byte, queueing any result beat
    task automatic deframe_byte(input logic [7:0] b);
        stld_result_t beat;
        logic         last;
        case (deframe_phase)
            PH_SYNC2: begin
                if (b == sync_second_cfg)
                    deframe_phase = PH_TYPE;
                else if (b == sync_first_cfg)
                    deframe_phase = PH_SYNC2;
                else
                    deframe_phase = PH_HUNT;
            end
            PH_TYPE: begin
                held_type = b;
                deframe_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                held_len = {8'h00, b};
                deframe_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                held_len[15:8] = b;
                payload_count = '0;
                if (held_len > MAX_PAYLOAD) begin
                    deframe_phase = PH_HUNT;
                end else if (held_len == 16'd0) begin
                    beat = '{is_empty: 1'b1, is_last: 1'b1, byte_index: '0, data_byte: '0,
                             frame_length: held_len[7:0], frame_type: held_type};
                    frame_beats_due.push_back(beat);
                    deframe_phase = PH_HUNT;
                end else begin
                    deframe_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                last = (16'(payload_count) + 16'd1 >= held_len);
                beat = '{is_empty: 1'b0, is_last: last, byte_index: payload_count[6:0],
                         data_byte: b, frame_length: held_len[7:0], frame_type: held_type};
                frame_beats_due.push_back(beat);
                payload_count = payload_count + 11'd1;
                if (last)
                    deframe_phase = PH_HUNT;
            end
            default: begin
                deframe_phase = (b == sync_first_cfg) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
    endtask

    // Byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (bytes_to_send.size() != 0 &&
                             (!bytes_to_send[0].drain ||
                              (!s_tvalid && !m_tvalid && frame_beats_due.size() == 0))) begin
                    next_byte = bytes_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.value;
                    send_gap <= quiet ? 0 : $urandom_range(0, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_beat = '{is_empty: m_tuser, is_last: m_tlast, byte_index: m_tdata[30:24],
                             data_byte: m_tdata[23:16], frame_length: m_tdata[15:8],
                             frame_type: m_tdata[7:0]};
                if (frame_beats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: tdata %h tlast %b tuser %b",
                                 m_tdata, m_tlast, m_tuser);
                end else begin
                    want_beat = frame_beats_due.pop_front();
                    if (got_beat !== want_beat || m_tdata[31] !== 1'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"beat mismatch: exp type %h len %h data %h idx %0d ",
                                      "last %b empty %b, got type %h len %h data %h idx %0d ",
                                      "last %b empty %b pad %b"},
                                     want_beat.frame_type, want_beat.frame_length,
                                     want_beat.data_byte, want_beat.byte_index,
                                     want_beat.is_last, want_beat.is_empty,
                                     got_beat.frame_type, got_beat.frame_length,
                                     got_beat.data_byte, got_beat.byte_index,
                                     got_beat.is_last, got_beat.is_empty, m_tdata[31]);
                    end
                end
            end
            if (!m_tready) begin
                if (stall_left > 0)
                    stall_left <= stall_left - 1;
                else
                    m_tready <= 1'b1;
            end else if ((m_tvalid && m_tready) || $urandom_range(0, 7) == 0) begin
                stall_draw = quiet ? 0 : $urandom_range(0, 3);
                if (stall_draw > 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= stall_draw - 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        link_byte_t item;
        item.value = b;
        item.drain = hold_for_drain;
        hold_for_drain = 1'b0;
        bytes_to_send.push_back(item);
    endtask

    // Header with the current sync bytes, then n_payload random payload bytes
    task automatic send_frame(input logic [7:0] typ, input logic [15:0] len,
                              input int n_payload);
        send_byte(sync_first_cfg);
        send_byte(sync_second_cfg);
        send_byte(typ);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < n_payload; i++)
            send_byte(8'($urandom));
    endtask

    // Wait until every byte is taken and every result has arrived
    task automatic wait_drained;
        do
            @(negedge aclk);
        while (bytes_to_send.size() != 0 || s_tvalid || m_tvalid ||
               frame_beats_due.size() != 0);
    endtask

    task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_wdata <= first;
        @(posedge aclk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_wdata <= second;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sync_first_cfg  = first;
        sync_second_cfg = second;
        @(negedge aclk);
    endtask

    // Stimulus
    initial begin
        logic [7:0]  firsts  [N_PHASES];
        logic [7:0]  seconds [N_PHASES];
        logic [15:0] len;
        int          sent;
        int          pick;
        int          noise_n;

        firsts  = '{8'h5a, 8'h00, 8'hff, 8'ha5, 8'($urandom)};
        seconds = '{8'h50, 8'hff, 8'h00, 8'ha5, 8'($urandom)};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: noise while hunting, empty frame, repeated first sync,
        // wrong second sync, oversized lengths in either length byte
        send_byte(8'h00);
        send_byte(8'hff);
        send_frame(8'hff, 16'd0, 0);
        send_byte(sync_first_cfg);
        send_frame(8'h00, 16'd2, 0);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(sync_first_cfg);
        send_byte(8'h00);
        send_frame(8'h81, 16'd129, 0);
        send_frame(8'h7e, 16'h0100, 0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            repeat (3) @(posedge aclk);
            write_sync(firsts[ph], seconds[ph]);
            quiet = (ph == 2);
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                // pause the link in the middle of each phase until all results are back
                if (sent >= BYTES_PER_PHASE / 2 && sent < BYTES_PER_PHASE / 2 + 8)
                    hold_for_drain = 1'b1;
                pick = $urandom_range(0, 9);
                if (pick <= 5 || pick == 8) begin
                    if (pick == 8) begin
                        send_byte(sync_first_cfg);
                        sent++;
                    end
                    case ($urandom_range(0, 19))
                        0:       len = 16'd0;
                        1:       len = 16'd128;
                        2:       len = 16'($urandom_range(17, 127));
                        default: len = 16'($urandom_range(1, 16));
                    endcase
                    send_frame(8'($urandom), len, int'(len));
                    sent += 5 + int'(len);
                end else if (pick == 6) begin
                    send_frame(8'($urandom), 16'($urandom_range(129, 65535)), 0);
                    sent += 5;
                end else if (pick == 7) begin
                    // first sync followed by an arbitrary byte
                    send_byte(sync_first_cfg);
                    send_byte(8'($urandom));
                    sent += 2;
                end else begin
                    noise_n = $urandom_range(1, 4);
                    repeat (noise_n)
                        send_byte(8'($urandom));
                    sent += noise_n;
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && frame_beats_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
